// File: hw/rtl/vfc_pkg.sv
// Shared types, constants and helper functions for the VBI frame code generator.
package vfc_pkg;

	localparam int FRAME_W      = 21;
	localparam int CODE_W       = 24;
	localparam int CHIPS_W      = 48;
	localparam int ADDR_W       = 17;
	localparam int CFG_W        = 12;
	localparam int DIGIT_STAGES = 6;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [FRAME_W-1:0] PIC_LIMIT_NTSC = 21'd79999;
	localparam logic [FRAME_W-1:0] PIC_LIMIT_PAL  = 21'd99999;
	localparam logic [FRAME_W-1:0] TC_LIMIT_NTSC  = 21'd1079970;
	localparam logic [FRAME_W-1:0] TC_LIMIT_PAL   = 21'd899975;

	localparam logic [23:0] HOUR_NTSC   = 24'd108000;
	localparam logic [23:0] HOUR_PAL    = 24'd90000;
	localparam logic [23:0] MINUTE_NTSC = 24'd1800;
	localparam logic [23:0] MINUTE_PAL  = 24'd1500;
	localparam logic [23:0] FPS_NTSC    = 24'd30;
	localparam logic [23:0] FPS_PAL     = 24'd25;

	localparam logic [3:0] KEY_F        = 4'hF;
	localparam logic [3:0] KEY_8        = 4'h8;
	localparam logic [3:0] KEY_E        = 4'hE;
	localparam logic [3:0] KEY_D        = 4'hD;
	localparam logic [3:0] SEC_TENS_KEY = 4'hA;

	localparam logic [11:0] LINE_WIDTH_RST      = 12'd910;
	localparam logic [7:0]  SAMPLES_PER_BIT_RST = 8'd28;
	localparam logic [4:0]  FIRST_CODE_LINE     = 5'd15;

	typedef enum logic [2:0] {
		REG_PAL_MODE,
		REG_PICTURE_NUMBER_MODE,
		REG_LINE_WIDTH,
		REG_ACTIVE_START,
		REG_SAMPLES_PER_BIT
	} reg_index_t;

	typedef struct packed {
		logic [3:0]         q;
		logic [FRAME_W-1:0] r;
	} step_t;

	typedef struct packed {
		logic              err;
		logic              pic;
		logic [CODE_W-1:0] c0;
		logic [CODE_W-1:0] c1;
	} entry_t;

	function automatic logic [23:0] divisor(input logic [2:0] stage, input logic pic,
		input logic pal);
		logic [23:0] d;
		if (pic) begin
			case (stage)
				3'd0:    d = 24'd1000000;
				3'd1:    d = 24'd100000;
				3'd2:    d = 24'd10000;
				3'd3:    d = 24'd1000;
				3'd4:    d = 24'd100;
				default: d = 24'd10;
			endcase
		end else begin
			case (stage)
				3'd0:    d = pal ? HOUR_PAL : HOUR_NTSC;
				3'd1:    d = 24'd10 * (pal ? MINUTE_PAL : MINUTE_NTSC);
				3'd2:    d = pal ? MINUTE_PAL : MINUTE_NTSC;
				3'd3:    d = 24'd10 * (pal ? FPS_PAL : FPS_NTSC);
				3'd4:    d = pal ? FPS_PAL : FPS_NTSC;
				default: d = 24'd10;
			endcase
		end
		return d;
	endfunction

	function automatic step_t digit_step(input logic [FRAME_W-1:0] v, input logic [23:0] d);
		step_t       s;
		logic [23:0] m;
		logic [23:0] sel;
		s.q = '0;
		sel = '0;
		for (int j = 1; j <= 9; j++) begin
			m = 24'(j) * d;
			if ({3'b0, v} >= m) begin
				s.q = 4'(j);
				sel = m;
			end
		end
		s.r = FRAME_W'({3'b0, v} - sel);
		return s;
	endfunction

endpackage

// File: hw/rtl/vfc_front.sv
// Front end: range check and pipelined decimal split of the frame number into code words.
module vfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pal_mode,
	input  logic                          picture_number_mode,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vfc_pkg::FRAME_W-1:0]   frame_number,
	output logic                          ent_valid,
	input  logic                          ent_ready,
	output vfc_pkg::entry_t               ent
);

	localparam int NST = vfc_pkg::DIGIT_STAGES;

	logic [NST:0]                   vld_q;
	logic [NST+1:0]                 rdy;
	logic [vfc_pkg::FRAME_W-1:0]    rem_q [0:NST];
	logic [23:0]                    dig_q [0:NST];
	logic [NST:0]                   err_q;
	vfc_pkg::step_t                 stp [1:NST];
	logic [vfc_pkg::FRAME_W-1:0]    limit;
	logic                           over;
	logic [3:0]                     q0, q1, q2, q3, q4, q5, fu;

	always_comb begin
		if (picture_number_mode)
			limit = pal_mode ? vfc_pkg::PIC_LIMIT_PAL : vfc_pkg::PIC_LIMIT_NTSC;
		else
			limit = pal_mode ? vfc_pkg::TC_LIMIT_PAL : vfc_pkg::TC_LIMIT_NTSC;
		over = frame_number > limit;
	end

	always_comb begin
		rdy[NST+1] = ent_ready;
		for (int k = NST; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_comb begin
		for (int k = 1; k <= NST; k++)
			stp[k] = vfc_pkg::digit_step(rem_q[k-1],
				vfc_pkg::divisor(3'(k-1), picture_number_mode, pal_mode));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k <= NST; k++)
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			rem_q[0] <= frame_number;
			dig_q[0] <= '0;
			err_q[0] <= over;
		end
		for (int k = 1; k <= NST; k++) begin
			if (vld_q[k-1] && rdy[k]) begin
				rem_q[k] <= stp[k].r;
				dig_q[k] <= {dig_q[k-1][19:0], stp[k].q};
				err_q[k] <= err_q[k-1];
			end
		end
	end

	assign q0 = dig_q[NST][23:20];
	assign q1 = dig_q[NST][19:16];
	assign q2 = dig_q[NST][15:12];
	assign q3 = dig_q[NST][11:8];
	assign q4 = dig_q[NST][7:4];
	assign q5 = dig_q[NST][3:0];
	assign fu = rem_q[NST][3:0];

	assign in_ready  = rdy[0];
	assign ent_valid = vld_q[NST];

	always_comb begin
		ent.err = err_q[NST];
		ent.pic = picture_number_mode;
		ent.c0  = {vfc_pkg::KEY_8, 4'(vfc_pkg::SEC_TENS_KEY + q3), vfc_pkg::KEY_E, q4, q5, fu};
		if (picture_number_mode)
			ent.c1 = {vfc_pkg::KEY_F, q2, q3, q4, q5, fu};
		else
			ent.c1 = {vfc_pkg::KEY_F, q0, vfc_pkg::KEY_D, vfc_pkg::KEY_D, q1, q2};
	end

endmodule

// File: hw/rtl/vfc_fifo.sv
// Short show-ahead queue of code entries between the front and back ends.
module vfc_fifo #(
	parameter int DEPTH = vfc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  vfc_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output vfc_pkg::entry_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vfc_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_q + 1'b1);
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_q + 1'b1);
			if (push && !pop)
				cnt_q <= CW'(cnt_q + 1'b1);
			else if (pop && !push)
				cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// File: hw/rtl/vfc_back.sv
// Back end: expands each queued entry into line results held in the output register.
module vfc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [11:0]                   line_width,
	input  logic [11:0]                   active_start,
	input  logic [7:0]                    samples_per_bit,
	input  logic                          head_valid,
	output logic                          head_ready,
	input  vfc_pkg::entry_t               head,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    line_slot,
	output logic [vfc_pkg::ADDR_W-1:0]    start_address,
	output logic [vfc_pkg::CODE_W-1:0]    code_word,
	output logic [vfc_pkg::CHIPS_W-1:0]   chips,
	output logic [6:0]                    first_half_samples,
	output logic [7:0]                    second_half_samples,
	output logic                          range_error,
	output logic                          last
);

	logic [1:0]                    idx_q;
	logic                          ov_q;
	logic [1:0]                    slot_q;
	logic [vfc_pkg::ADDR_W-1:0]    addr_q;
	logic [vfc_pkg::CODE_W-1:0]    code_q;
	logic [vfc_pkg::CHIPS_W-1:0]   chips_q;
	logic [6:0]                    fh_q;
	logic [7:0]                    sh_q;
	logic                          err_q;
	logic                          last_q;

	logic                          load;
	logic                          is_last;
	logic [1:0]                    slot;
	logic [4:0]                    line_no;
	logic [vfc_pkg::ADDR_W-1:0]    addr;
	logic [vfc_pkg::CODE_W-1:0]    code;
	logic [vfc_pkg::CHIPS_W-1:0]   chp;
	logic [6:0]                    fh;
	logic [7:0]                    sh;

	function automatic logic [vfc_pkg::CHIPS_W-1:0] manchester(
		input logic [vfc_pkg::CODE_W-1:0] c);
		logic [vfc_pkg::CHIPS_W-1:0] r;
		for (int k = 0; k < vfc_pkg::CODE_W; k++)
			r[2*k +: 2] = {~c[k], c[k]};
		return r;
	endfunction

	always_comb begin
		if (head.err)
			is_last = 1'b1;
		else if (head.pic)
			is_last = idx_q == 2'd1;
		else
			is_last = idx_q == 2'd2;
		slot    = head.pic ? 2'(idx_q + 1'b1) : idx_q;
		line_no = 5'(vfc_pkg::FIRST_CODE_LINE + {3'b0, slot});
		addr    = vfc_pkg::ADDR_W'({12'b0, line_no} * {5'b0, line_width})
		        + {5'b0, active_start};
		code    = (slot == 2'd0) ? head.c0 : head.c1;
		chp     = manchester(code);
		fh      = samples_per_bit[7:1];
		sh      = samples_per_bit - {1'b0, fh};
		load    = head_valid && (!ov_q || out_ready);
	end

	assign head_ready = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			if (load)
				idx_q <= is_last ? 2'd0 : 2'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_q  <= head.err;
			last_q <= is_last;
			if (head.err) begin
				slot_q  <= '0;
				addr_q  <= '0;
				code_q  <= '0;
				chips_q <= '0;
				fh_q    <= '0;
				sh_q    <= '0;
			end else begin
				slot_q  <= slot;
				addr_q  <= addr;
				code_q  <= code;
				chips_q <= chp;
				fh_q    <= fh;
				sh_q    <= sh;
			end
		end
	end

	assign out_valid           = ov_q;
	assign line_slot           = slot_q;
	assign start_address       = addr_q;
	assign code_word           = code_q;
	assign chips               = chips_q;
	assign first_half_samples  = fh_q;
	assign second_half_samples = sh_q;
	assign range_error         = err_q;
	assign last                = last_q;

endmodule

// File: hw/rtl/vbi_frame_code_manchester.sv
// Top level of the VBI frame code generator: configuration registers, front, queue, back.
// Each frame number enters a seven-stage pipeline that checks its range and splits it into
// decimal digits one digit per stage, so a new frame number is taken every cycle while
// there is room. Results leave through the output register one line per cycle while the
// receiver is ready: a timecode frame number yields three lines, a picture number two,
// an over-range number one. Its first line comes after the front pipeline, the queue and
// the output register. Configuration writes take effect on the next cycle.
module vbi_frame_code_manchester #(
	parameter int QUEUE_DEPTH = vfc_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [vfc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vfc_pkg::FRAME_W-1:0]   frame_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    line_slot,
	output logic [vfc_pkg::ADDR_W-1:0]    start_address,
	output logic [vfc_pkg::CODE_W-1:0]    code_word,
	output logic [vfc_pkg::CHIPS_W-1:0]   chips,
	output logic [6:0]                    first_half_samples,
	output logic [7:0]                    second_half_samples,
	output logic                          range_error,
	output logic                          last
);

	logic            pal_q;
	logic            pic_q;
	logic [11:0]     line_width_q;
	logic [11:0]     active_start_q;
	logic [7:0]      spb_q;

	logic            ent_valid;
	logic            ent_ready;
	vfc_pkg::entry_t ent;
	logic            head_valid;
	logic            head_ready;
	vfc_pkg::entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q          <= 1'b0;
			pic_q          <= 1'b0;
			line_width_q   <= vfc_pkg::LINE_WIDTH_RST;
			active_start_q <= '0;
			spb_q          <= vfc_pkg::SAMPLES_PER_BIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				vfc_pkg::REG_PAL_MODE:            pal_q          <= cfg_wdata[0];
				vfc_pkg::REG_PICTURE_NUMBER_MODE: pic_q          <= cfg_wdata[0];
				vfc_pkg::REG_LINE_WIDTH:          line_width_q   <= cfg_wdata;
				vfc_pkg::REG_ACTIVE_START:        active_start_q <= cfg_wdata;
				vfc_pkg::REG_SAMPLES_PER_BIT:     spb_q          <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	vfc_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.pal_mode            (pal_q),
		.picture_number_mode (pic_q),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.frame_number        (frame_number),
		.ent_valid           (ent_valid),
		.ent_ready           (ent_ready),
		.ent                 (ent)
	);

	vfc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (ent_valid),
		.push_ready (ent_ready),
		.push_data  (ent),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head)
	);

	vfc_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.line_width          (line_width_q),
		.active_start        (active_start_q),
		.samples_per_bit     (spb_q),
		.head_valid          (head_valid),
		.head_ready          (head_ready),
		.head                (head),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.line_slot           (line_slot),
		.start_address       (start_address),
		.code_word           (code_word),
		.chips               (chips),
		.first_half_samples  (first_half_samples),
		.second_half_samples (second_half_samples),
		.range_error         (range_error),
		.last                (last)
	);

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> last && code_word == '0 && chips == '0)
		else $error("range error result not a lone zeroed item");

	a_slot0_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error && line_slot == 2'd0 |-> !last)
		else $error("timecode first line marked last");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error && last |-> line_slot == 2'd2)
		else $error("final line of an item is not the third slot");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid |-> !range_error
		&& line_slot == 2'($past(line_slot) + 1'b1))
		else $error("line slots out of order within an item");

endmodule

// File: bench/tb.sv
// Testbench for the VBI frame code generator: queue-fed driver, checking monitor, register phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vfc_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd6;

	typedef struct packed {
		logic [1:0]         slot;
		logic [ADDR_W-1:0]  addr;
		logic [CODE_W-1:0]  code;
		logic [CHIPS_W-1:0] chips;
		logic [6:0]         half1;
		logic [7:0]         half2;
		logic               err;
		logic               fin;
	} code_line_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_addr = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FRAME_W-1:0]  frame_number = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          line_slot;
	logic [ADDR_W-1:0]   start_address;
	logic [CODE_W-1:0]   code_word;
	logic [CHIPS_W-1:0]  chips;
	logic [6:0]          first_half_samples;
	logic [7:0]          second_half_samples;
	logic                range_error;
	logic                last;

	logic                cfg_pal = 1'b0;
	logic                cfg_pic = 1'b0;
	logic [11:0]         cfg_line_width = LINE_WIDTH_RST;
	logic [11:0]         cfg_active_start = '0;
	logic [7:0]          cfg_spb = SAMPLES_PER_BIT_RST;

	logic [FRAME_W-1:0]  frame_queue[$];
	code_line_t          line_expect[$];
	int                  send_idle = 0;
	int                  recv_stall = 0;
	int                  err_count = 0;
	int                  frames_sent = 0;
	int                  lines_checked = 0;
	int                  settings_used = 1;

	vbi_frame_code_manchester u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_addr           (cfg_addr),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.frame_number       (frame_number),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.line_slot          (line_slot),
		.start_address      (start_address),
		.code_word          (code_word),
		.chips              (chips),
		.first_half_samples (first_half_samples),
		.second_half_samples(second_half_samples),
		.range_error        (range_error),
		.last               (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [CHIPS_W-1:0] manchester_chips(input logic [CODE_W-1:0] code);
		logic [CHIPS_W-1:0] c;
		c = '0;
		for (int k = CODE_W - 1; k >= 0; k--)
			c = {c[CHIPS_W-3:0], (code[k] ? 2'b01 : 2'b10)};
		return c;
	endfunction

	function automatic int unsigned frame_limit();
		if (cfg_pic)
			return cfg_pal ? int'(PIC_LIMIT_PAL) : int'(PIC_LIMIT_NTSC);
		return cfg_pal ? int'(TC_LIMIT_PAL) : int'(TC_LIMIT_NTSC);
	endfunction

	function automatic void push_line(input logic [1:0] slot, input logic [CODE_W-1:0] code,
		input logic fin);
		code_line_t  l;
		int unsigned a;
		a = (int'(FIRST_CODE_LINE) + slot) * cfg_line_width + cfg_active_start;
		l.slot  = slot;
		l.addr  = a[ADDR_W-1:0];
		l.code  = code;
		l.chips = manchester_chips(code);
		l.half1 = cfg_spb[7:1];
		l.half2 = cfg_spb - {1'b0, cfg_spb[7:1]};
		l.err   = 1'b0;
		l.fin   = fin;
		line_expect.push_back(l);
	endfunction

	function automatic void predict_frame(input logic [FRAME_W-1:0] n);
		code_line_t        l;
		int unsigned       v, fps, per_hour, per_min, hour, minute, sec, frm, rest;
		logic [CODE_W-1:0] c0, c1;
		v = n;
		if (v > frame_limit()) begin
			l = '0;
			l.err = 1'b1;
			l.fin = 1'b1;
			line_expect.push_back(l);
		end else if (cfg_pic) begin
			c0 = {KEY_F, 4'(v / 10000 % 10), 4'(v / 1000 % 10), 4'(v / 100 % 10),
				4'(v / 10 % 10), 4'(v % 10)};
			push_line(2'd1, c0, 1'b0);
			push_line(2'd2, c0, 1'b1);
		end else begin
			fps      = cfg_pal ? FPS_PAL : FPS_NTSC;
			per_hour = cfg_pal ? HOUR_PAL : HOUR_NTSC;
			per_min  = cfg_pal ? MINUTE_PAL : MINUTE_NTSC;
			hour     = v / per_hour;
			rest     = v % per_hour;
			minute   = rest / per_min;
			rest     = rest % per_min;
			sec      = rest / fps;
			frm      = rest % fps;
			c0 = {KEY_8, 4'(SEC_TENS_KEY + sec / 10 % 10), KEY_E, 4'(sec % 10),
				4'(frm / 10 % 10), 4'(frm % 10)};
			c1 = {KEY_F, 4'(hour), KEY_D, KEY_D, 4'(minute / 10 % 10), 4'(minute % 10)};
			push_line(2'd0, c0, 1'b0);
			push_line(2'd1, c1, 1'b0);
			push_line(2'd2, c1, 1'b1);
		end
	endfunction

	function automatic logic [FRAME_W-1:0] pick_frame();
		int unsigned lim, r;
		lim = frame_limit();
		r = $urandom_range(99);
		if (r < 72)
			return FRAME_W'($urandom_range(lim));
		if (r < 84)
			return FRAME_W'(lim - 2 + $urandom_range(4));
		return FRAME_W'($urandom_range(2 ** FRAME_W - 1));
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
			err_count++;
		end
	endtask

	task automatic check_line();
		code_line_t e;
		if (line_expect.size() == 0) begin
			$display("%0t: unexpected code line, expected none, got slot %0d code %0h",
				$time, line_slot, code_word);
			err_count++;
		end else begin
			e = line_expect.pop_front();
			check_field("line_slot", e.slot, line_slot);
			check_field("start_address", e.addr, start_address);
			check_field("code_word", e.code, code_word);
			check_field("chips", e.chips, chips);
			check_field("first_half_samples", e.half1, first_half_samples);
			check_field("second_half_samples", e.half2, second_half_samples);
			check_field("range_error", e.err, range_error);
			check_field("last", e.fin, last);
			lines_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			frame_number <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_frame(frame_number);
				frames_sent++;
			end
			if (in_valid && !in_ready) begin
				// hold the item until taken
			end else if (frame_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
				in_valid <= 1'b1;
				frame_number <= frame_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_line();
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_PAL_MODE: begin
				cfg_pal = value[0];
			end
			REG_PICTURE_NUMBER_MODE: begin
				cfg_pic = value[0];
			end
			REG_LINE_WIDTH: begin
				cfg_line_width = value;
			end
			REG_ACTIVE_START: begin
				cfg_active_start = value;
			end
			REG_SAMPLES_PER_BIT: begin
				cfg_spb = value[7:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic pal, input logic pic, input logic [11:0] lw,
		input logic [11:0] act, input logic [7:0] spb, input bit poke_spare);
		write_reg(REG_PAL_MODE, {11'($urandom), pal});
		write_reg(REG_PICTURE_NUMBER_MODE, {11'($urandom), pic});
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_ACTIVE_START, act);
		write_reg(REG_SAMPLES_PER_BIT, {4'($urandom), spb});
		if (poke_spare)
			write_reg(REG_SPARE, '1);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
		settings_used++;
	endtask

	task automatic add_random(input int count);
		repeat (count) frame_queue.push_back(pick_frame());
	endtask

	task automatic drain();
		while (frame_queue.size() != 0 || in_valid || line_expect.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle = 0;
		recv_stall = 0;
		frame_queue = {21'd0, 21'd29, 21'd30, 21'd1799, 21'd1800, 21'd107999,
			21'd1079970, 21'd1079971, 21'd2097151};
		add_random(20);
		drain();

		set_config(1'b1, 1'b0, 12'd4095, 12'd4095, 8'd255, 1'b0);
		send_idle = 66;
		frame_queue = {21'd24, 21'd25, 21'd1500, 21'd89999, 21'd90000, 21'd899975,
			21'd899976};
		add_random(25);
		drain();

		set_config(1'b0, 1'b1, 12'd1, 12'd0, 8'd2, 1'b0);
		send_idle = 0;
		recv_stall = 66;
		frame_queue = {21'd79999, 21'd80000, 21'd13579};
		add_random(25);
		drain();

		set_config(1'b1, 1'b1, 12'($urandom), 12'($urandom), 8'd3, 1'b0);
		send_idle = 29;
		recv_stall = 29;
		frame_queue = {21'd99999, 21'd100000, 21'd24680};
		add_random(25);
		drain();

		set_config(1'b0, 1'b0, 12'd0, 12'($urandom), 8'd1, 1'b1);
		send_idle = 0;
		recv_stall = 0;
		add_random(20);
		drain();

		set_config(1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom), 8'd0, 1'b0);
		send_idle = 29;
		recv_stall = 29;
		add_random(25);
		drain();

		$display("Sent %0d frame numbers under %0d register settings, checked %0d code lines",
			frames_sent, settings_used, lines_checked);
		$display("Covered NTSC and PAL timecode, picture numbers, over-range and bit sizes 0-255");
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("Timeout with %0d code lines outstanding", line_expect.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
